FILE: rtl/gsl_pkg.sv
// Shared constants and types for the gain stage with soft-knee limiter.
`timescale 1ns / 1ps
package gsl_pkg;

  // Default sample width, Q1.(N-1)
  localparam int unsigned DEF_SAMPLE_BITS = 24;

  // Gain register, unsigned Q2.14
  localparam int unsigned GAIN_BITS = 16;
  localparam int unsigned GAIN_FRAC = 14;
  localparam logic [GAIN_BITS-1:0] GAIN_ONE = 16'd16384;
  localparam logic [GAIN_BITS-1:0] GAIN_MAX = 16'd32768;

  // Default widths of the divider chain, derived from the sample width
  localparam int unsigned DEF_MAG_BITS = DEF_SAMPLE_BITS + 1;
  localparam int unsigned DEF_REM_BITS = 2 * DEF_SAMPLE_BITS + 4;
  localparam int unsigned DEF_QUO_BITS = DEF_SAMPLE_BITS - 4;

  // Per-request control that rides along the pipeline
  typedef struct packed {
    logic valid;
    logic neg;
    logic lim;
    logic knee;
  } gsl_ctl_t;

endpackage

FILE: rtl/gain_with_soft_limiter_top.sv
// Top level: gain multiply, rounding, knee detection, divider chain and output saturation.
`timescale 1ns / 1ps
// Path of a request: stages 1 to 5, the divider chain, the final stage, then the done_o and output registers.
// Throughput: one request per cycle; busy_o is never raised, the pipeline has no stalls.
// The divider chain has one cell and one quotient bit per stage.
// The receiver cannot stall: each result is on sample_out_o for the single cycle done_o is high.
// Reset (async, active low) empties the pipeline and sets the gain to 1.0.
module gain_with_soft_limiter_top import gsl_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          gain_we_i,
  input  logic [GAIN_BITS-1:0]          gain_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          done_o,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o
);

  // Widths. Magnitudes after gain reach 2.0, hence one extra bit.
  localparam int unsigned B        = SAMPLE_BITS;
  localparam int unsigned MAG_BITS = B + 1;
  localparam int unsigned PROD_BITS = B + GAIN_BITS;
  localparam int unsigned M20_BITS = B + 5;      // 20*m < 2^(B+5)
  localparam int unsigned D_BITS   = B + 4;      // d <= 22*U
  localparam int unsigned REM_BITS = 2 * B + 4;  // holds 40*d shifted up to the top quotient bit
  localparam int unsigned QUO_BITS = B - 4;      // r < U/16

  // Fixed-point constants, U = 1.0
  localparam logic [MAG_BITS-1:0]  U_MAG     = MAG_BITS'(1) << (B - 1);
  localparam logic [MAG_BITS-1:0]  U_MAG_M1  = U_MAG - MAG_BITS'(1);
  localparam logic [M20_BITS-1:0]  U_WIDE    = M20_BITS'(1) << (B - 1);
  localparam logic [M20_BITS-1:0]  KNEE_20   = U_WIDE * M20_BITS'(19);  // 20*m > 19*U: above 0.95
  localparam logic [M20_BITS-1:0]  OFFS_20   = U_WIDE * M20_BITS'(18);
  localparam logic [D_BITS-1:0]    D_IDLE    = D_BITS'(U_WIDE);
  localparam logic [REM_BITS-1:0]  TWO_U_SQ  = REM_BITS'(1) << (2 * B - 1);
  localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (GAIN_FRAC - 1);
  localparam logic [MAG_BITS-1:0]  LIM_FLOOR = U_MAG - (U_MAG >> 4);

  // ---------------------------------------------------------------
  // Gain register, saturated to 2.0 on write
  // ---------------------------------------------------------------
  logic [GAIN_BITS-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_ONE;
    end else if (gain_we_i) begin
      gain_q <= (gain_wdata_i > GAIN_MAX) ? GAIN_MAX : gain_wdata_i;
    end
  end

  // Never stalls: a request is taken every cycle that start_i is high.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------
  // Stage 1: split sign and magnitude
  // ---------------------------------------------------------------
  gsl_ctl_t       s1_ctl_d, s1_ctl_q;
  logic [B-1:0]   s1_mag_d, s1_mag_q;

  always_comb begin
    s1_ctl_d       = '0;
    s1_ctl_d.valid = start_i & ~busy_o;
    s1_ctl_d.neg   = sample_in_i[B-1];
    // -(-1.0) = U still fits B unsigned bits
    s1_mag_d = sample_in_i[B-1] ? (~B'(sample_in_i) + B'(1)) : B'(sample_in_i);
  end

  // ---------------------------------------------------------------
  // Stage 2: multiply by gain
  // ---------------------------------------------------------------
  gsl_ctl_t               s2_ctl_d, s2_ctl_q;
  logic [PROD_BITS-1:0]   s2_prod_d, s2_prod_q;

  always_comb begin
    s2_ctl_d     = s1_ctl_q;
    s2_ctl_d.lim = (gain_q > GAIN_ONE);
    s2_prod_d    = PROD_BITS'(s1_mag_q) * PROD_BITS'(gain_q);
  end

  // ---------------------------------------------------------------
  // Stage 3: round to nearest, ties away from zero (on the magnitude)
  // ---------------------------------------------------------------
  gsl_ctl_t              s3_ctl_q;
  logic [PROD_BITS-1:0]  s3_sum;
  logic [MAG_BITS-1:0]   s3_m_d, s3_m_q;

  always_comb begin
    s3_sum = s2_prod_q + ROUND_HALF;
    s3_m_d = s3_sum[GAIN_FRAC +: MAG_BITS];
  end

  // ---------------------------------------------------------------
  // Stage 4: knee test and D = 20*m - 18*U
  // ---------------------------------------------------------------
  gsl_ctl_t              s4_ctl_d, s4_ctl_q;
  logic [M20_BITS-1:0]   s4_m20;
  logic [D_BITS-1:0]     s4_d_d, s4_d_q;
  logic [MAG_BITS-1:0]   s4_m_q;

  always_comb begin
    s4_m20        = (M20_BITS'(s3_m_q) << 4) + (M20_BITS'(s3_m_q) << 2);
    s4_ctl_d      = s3_ctl_q;
    s4_ctl_d.knee = s3_ctl_q.lim & (s4_m20 > KNEE_20);
    // outside the knee the divider still runs, on a harmless operand
    s4_d_d        = s4_ctl_d.knee ? D_BITS'(s4_m20 - OFFS_20) : D_IDLE;
  end

  // ---------------------------------------------------------------
  // Stage 5: dividend 2*U^2 + 20*D, divisor 40*D aligned to the top quotient bit.
  // The quotient is U^2/(20*D) rounded, ties up.
  // ---------------------------------------------------------------
  gsl_ctl_t              s5_ctl_q;
  logic [MAG_BITS-1:0]   s5_m_q;
  logic [REM_BITS-1:0]   s5_d_wide;
  logic [REM_BITS-1:0]   s5_num_d, s5_num_q;
  logic [REM_BITS-1:0]   s5_dv_d, s5_dv_q;

  always_comb begin
    s5_d_wide = REM_BITS'(s4_d_q);
    s5_num_d  = TWO_U_SQ + (s5_d_wide << 4) + (s5_d_wide << 2);
    s5_dv_d   = ((s5_d_wide << 5) + (s5_d_wide << 3)) << (QUO_BITS - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
      s4_ctl_q <= '0;
      s5_ctl_q <= '0;
    end else begin
      s1_ctl_q <= s1_ctl_d;
      s2_ctl_q <= s2_ctl_d;
      s3_ctl_q <= s2_ctl_q;
      s4_ctl_q <= s4_ctl_d;
      s5_ctl_q <= s4_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mag_q  <= s1_mag_d;
    s2_prod_q <= s2_prod_d;
    s3_m_q    <= s3_m_d;
    s4_m_q    <= s3_m_q;
    s4_d_q    <= s4_d_d;
    s5_m_q    <= s4_m_q;
    s5_num_q  <= s5_num_d;
    s5_dv_q   <= s5_dv_d;
  end

  // ---------------------------------------------------------------
  // Divider chain: one restoring step per cell, MSB of the quotient first
  // ---------------------------------------------------------------
  gsl_ctl_t            c_ctl [QUO_BITS+1];
  logic [MAG_BITS-1:0] c_mag [QUO_BITS+1];
  logic [REM_BITS-1:0] c_rem [QUO_BITS+1];
  logic [REM_BITS-1:0] c_dv  [QUO_BITS+1];
  logic [QUO_BITS-1:0] c_quo [QUO_BITS+1];

  assign c_ctl[0] = s5_ctl_q;
  assign c_mag[0] = s5_m_q;
  assign c_rem[0] = s5_num_q;
  assign c_dv[0]  = s5_dv_q;
  assign c_quo[0] = '0;

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_cell
    gsl_div_cell #(
      .MAG_BITS (MAG_BITS),
      .REM_BITS (REM_BITS),
      .QUO_BITS (QUO_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (c_ctl[k]),
      .mag_i  (c_mag[k]),
      .rem_i  (c_rem[k]),
      .dv_i   (c_dv[k]),
      .quo_i  (c_quo[k]),
      .ctl_o  (c_ctl[k+1]),
      .mag_o  (c_mag[k+1]),
      .rem_o  (c_rem[k+1]),
      .dv_o   (c_dv[k+1]),
      .quo_o  (c_quo[k+1])
    );
  end

  // ---------------------------------------------------------------
  // Final: limited magnitude U - r, then saturate and restore the sign
  // ---------------------------------------------------------------
  gsl_ctl_t            f1_ctl_q;
  logic [MAG_BITS-1:0] f1_mag_d, f1_mag_q;
  logic [MAG_BITS-1:0] out_mag;
  logic [B-1:0]        out_d;
  logic [B-1:0]        out_q;
  logic                done_q;

  assign f1_mag_d = c_ctl[QUO_BITS].knee ? (U_MAG - MAG_BITS'(c_quo[QUO_BITS]))
                                          : c_mag[QUO_BITS];

  always_comb begin
    if (f1_ctl_q.neg) begin
      out_mag = (f1_mag_q > U_MAG) ? U_MAG : f1_mag_q;
      out_d   = ~B'(out_mag) + B'(1);
    end else begin
      out_mag = (f1_mag_q > U_MAG_M1) ? U_MAG_M1 : f1_mag_q;
      out_d   = B'(out_mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_ctl_q <= '0;
      done_q   <= 1'b0;
    end else begin
      f1_ctl_q <= c_ctl[QUO_BITS];
      done_q   <= f1_ctl_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_mag_q <= f1_mag_d;
    out_q    <= out_d;
  end

  assign done_o       = done_q;
  assign sample_out_o = out_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // gain never exceeds 2.0
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q <= GAIN_MAX)
    else $error("gain register above 2.0");

  // a limited magnitude lies between 15/16 and 1.0
  a_knee_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f1_ctl_q.valid && f1_ctl_q.knee) |-> (f1_mag_q <= U_MAG && f1_mag_q > LIM_FLOOR))
    else $error("soft-limited magnitude out of range");

  // the divider leaves a remainder below the divisor 40*D
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_ctl[QUO_BITS].valid |->
      ((REM_BITS+1)'(c_rem[QUO_BITS]) < ((REM_BITS+1)'(c_dv[QUO_BITS]) << 1)))
    else $error("divider remainder not reduced");

endmodule

FILE: rtl/gsl_div_cell.sv
// One restoring-division cell of the limiter divider chain.
`timescale 1ns / 1ps
module gsl_div_cell import gsl_pkg::*; #(
  parameter int unsigned MAG_BITS = DEF_MAG_BITS,
  parameter int unsigned REM_BITS = DEF_REM_BITS,
  parameter int unsigned QUO_BITS = DEF_QUO_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gsl_ctl_t            ctl_i,
  input  logic [MAG_BITS-1:0] mag_i,
  input  logic [REM_BITS-1:0] rem_i,
  input  logic [REM_BITS-1:0] dv_i,
  input  logic [QUO_BITS-1:0] quo_i,
  output gsl_ctl_t            ctl_o,
  output logic [MAG_BITS-1:0] mag_o,
  output logic [REM_BITS-1:0] rem_o,
  output logic [REM_BITS-1:0] dv_o,
  output logic [QUO_BITS-1:0] quo_o
);

  gsl_ctl_t            ctl_q;
  logic [MAG_BITS-1:0] mag_q;
  logic [REM_BITS-1:0] rem_d, rem_q;
  logic [REM_BITS-1:0] dv_q;
  logic [QUO_BITS-1:0] quo_d, quo_q;
  logic                fits;

  // one quotient bit: trial subtract of the shifted divisor
  always_comb begin
    fits  = (rem_i >= dv_i);
    rem_d = fits ? (rem_i - dv_i) : rem_i;
    quo_d = {quo_i[QUO_BITS-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_i;
    rem_q <= rem_d;
    dv_q  <= dv_i >> 1;
    quo_q <= quo_d;
  end

  assign ctl_o = ctl_q;
  assign mag_o = mag_q;
  assign rem_o = rem_q;
  assign dv_o  = dv_q;
  assign quo_o = quo_q;

endmodule

FILE: verif/gain_with_soft_limiter_top_tb.sv
// Testbench for the gain stage with soft-knee limiter: directed table, then random phases.
`timescale 1ns / 1ps
module gain_with_soft_limiter_top_tb;
  import gsl_pkg::*;

  localparam int unsigned SW = DEF_SAMPLE_BITS;
  // Extra wait after the final drain: LATENCY with a little slack on top
  localparam int unsigned LATENCY = SW + 2;
  localparam int unsigned DRAIN_CYCLES = LATENCY + 8;
  // Worst quiet stretch: an idle burst, a drain before a gain write, the pipeline latency
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 170;
  localparam int unsigned N_PHASES = 12;
  localparam int GAIN_PICK_ANY = -1;    // any 16-bit write value, saturating ones included
  localparam int GAIN_PICK_BOOST = -2;  // somewhere on the limiter path, 1.0 < g <= 2.0

  typedef enum logic {ROW_GAIN, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e kind;
    int        value;   // gain write data or sample
    bit        fixed;   // result typed in below rather than predicted
    int        want;
  } stim_row_t;

  // Descriptor handed from the driver to the monitor for each request
  typedef struct {
    bit            fixed;
    logic [SW-1:0] want;
  } req_note_t;

  typedef struct {
    logic [SW-1:0] src;
    logic [SW-1:0] val;
  } out_expect_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          gain_we_i;
  logic [GAIN_BITS-1:0]          gain_wdata_i;
  logic                          start_i;
  logic                          busy_o;
  logic signed [SW-1:0]          sample_in_i;
  logic                          done_o;
  logic signed [SW-1:0]          sample_out_o;

  gain_with_soft_limiter_top #(
    .SAMPLE_BITS (SW)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gain_we_i    (gain_we_i),
    .gain_wdata_i (gain_wdata_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .sample_in_i  (sample_in_i),
    .done_o       (done_o),
    .sample_out_o (sample_out_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Directed part. Rows with fixed=1 carry a result that follows directly:
  // unit gain is a pass-through, zero gain mutes, half gain rounds ties away
  // from zero, and at 2.0 a product just under the 0.95 knee is left alone.
  // The rest are checked against the predictor.
  stim_row_t dir_rows [0:26] = '{
    '{ROW_SAMPLE, 0,         1, 0},           // gain still at its reset value 1.0
    '{ROW_SAMPLE, 8388607,   1, 8388607},
    '{ROW_SAMPLE, -8388608,  1, -8388608},
    '{ROW_SAMPLE, 1,         1, 1},
    '{ROW_SAMPLE, -1,        1, -1},
    '{ROW_GAIN,   0,         0, 0},           // mute
    '{ROW_SAMPLE, 12345,     1, 0},
    '{ROW_SAMPLE, -8388608,  1, 0},
    '{ROW_GAIN,   8192,      0, 0},           // 0.5
    '{ROW_SAMPLE, 1,         1, 1},           // 0.5 LSB tie rounds away from zero
    '{ROW_SAMPLE, -1,        1, -1},
    '{ROW_SAMPLE, 3,         1, 2},
    '{ROW_SAMPLE, -3,        1, -2},
    '{ROW_GAIN,   65535,     0, 0},           // saturates to 2.0
    '{ROW_SAMPLE, 3984588,   1, 7969176},     // last magnitude below the knee
    '{ROW_SAMPLE, -3984588,  1, -7969176},
    '{ROW_SAMPLE, 3984589,   0, 0},           // first one above it
    '{ROW_SAMPLE, 8388607,   0, 0},
    '{ROW_SAMPLE, -8388608,  0, 0},
    '{ROW_GAIN,   32769,     0, 0},           // one above the cap
    '{ROW_SAMPLE, 8388607,   0, 0},
    '{ROW_GAIN,   16385,     0, 0},           // smallest gain that enables the limiter
    '{ROW_SAMPLE, 8388607,   0, 0},
    '{ROW_SAMPLE, -8388608,  0, 0},
    '{ROW_GAIN,   16384,     0, 0},
    '{ROW_SAMPLE, 4194304,   1, 4194304},
    '{ROW_SAMPLE, -4194304,  1, -4194304}
  };

  int phase_gain [0:N_PHASES-1] = '{
    int'(GAIN_MAX), 0, 65535, int'(GAIN_ONE) + 1, int'(GAIN_ONE), 1,
    int'(GAIN_MAX) - 1, GAIN_PICK_ANY, GAIN_PICK_BOOST, GAIN_PICK_ANY,
    GAIN_PICK_BOOST, GAIN_PICK_BOOST
  };

  req_note_t            req_notes [$];
  out_expect_t          sample_out_q [$];
  logic [GAIN_BITS-1:0] gain_shadow = GAIN_ONE;
  int unsigned          n_fail;
  int unsigned          n_req;
  int unsigned          n_res;
  int unsigned          n_gain_writes;
  int unsigned          quiet_cycles;

  function automatic logic [GAIN_BITS-1:0] clamp_gain(logic [GAIN_BITS-1:0] v);
    return (v > GAIN_MAX) ? GAIN_MAX : v;
  endfunction

  // Gain, round half away from zero on the magnitude, rational soft knee
  // when the gain exceeds 1.0, then restore the sign and saturate.
  function automatic logic [SW-1:0] limited_gain(logic [SW-1:0] smp,
                                                 logic [GAIN_BITS-1:0] g);
    longint unsigned full;
    longint unsigned mag;
    longint unsigned m;
    longint unsigned d;
    longint unsigned den;
    longint unsigned r;
    longint unsigned t;
    longint          s;
    logic            neg;
    full = longint'(1) << (SW - 1);
    neg  = smp[SW-1];
    s    = longint'($signed(smp));
    mag  = neg ? longint'(-s) : longint'(s);
    m    = (mag * g + (longint'(1) << (GAIN_FRAC - 1))) >> GAIN_FRAC;
    if (g > GAIN_ONE && 20 * m > 19 * full) begin
      d   = 20 * m - 18 * full;
      den = 20 * d;
      r   = (2 * full * full + den) / (2 * den);
      m   = (r >= full) ? 0 : full - r;
    end
    if (neg) begin
      if (m > full) m = full;
      t = ~m + 1;
    end else begin
      if (m > full - 1) m = full - 1;
      t = m;
    end
    return t[SW-1:0];
  endfunction

  // Random sample, weighted toward the places where the arithmetic bends
  function automatic logic [SW-1:0] pick_sample(logic [GAIN_BITS-1:0] g);
    longint unsigned full;
    longint unsigned knee;
    longint unsigned mag;
    logic            neg;
    full = longint'(1) << (SW - 1);
    neg  = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: return SW'($urandom);
      1: mag = neg ? full : full - 1 - $urandom_range(0, 3);
      2: mag = $urandom_range(0, 64);
      3: mag = full - $urandom_range(1, 1 << 20);
      default: begin
        // land the product around the knee; with low gain anything goes
        if (g > GAIN_ONE) begin
          knee = (19 * full * GAIN_ONE) / (20 * longint'(g));
          mag  = knee + $urandom_range(0, 256) - 128;
          if (mag > full) mag = full;
        end else begin
          mag = $urandom_range(0, int'(full - 1));
        end
      end
    endcase
    if (!neg && mag > full - 1) mag = full - 1;
    return neg ? SW'(~mag + 1) : SW'(mag);
  endfunction

  // Request and result monitor; everything is sampled at the rising edge
  always @(posedge clk_i) begin
    req_note_t   note;
    out_expect_t e;
    if (rst_ni) begin
      if (gain_we_i) gain_shadow = clamp_gain(gain_wdata_i);
      if (start_i && !busy_o) begin
        note  = req_notes.pop_front();
        e.src = sample_in_i;
        e.val = note.fixed ? note.want : limited_gain(sample_in_i, gain_shadow);
        sample_out_q.push_back(e);
        n_req++;
      end
      if (done_o) begin
        n_res++;
        if (sample_out_q.size() == 0) begin
          $error("sample_out: result %0d with no request outstanding",
                 $signed(sample_out_o));
          n_fail++;
        end else begin
          e = sample_out_q.pop_front();
          if (sample_out_o !== e.val) begin
            $error("sample_out: expected %0d, actual %0d (sample_in %0d, gain %0d)",
                   $signed(e.val), $signed(sample_out_o), $signed(e.src), gain_shadow);
            n_fail++;
          end
        end
      end
    end
  end

  // Watchdog: quiet means neither a request nor a result this cycle
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles with no request or result", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold start_i high until the DUT takes the request
  task automatic send_request(logic [SW-1:0] smp, bit fixed, logic [SW-1:0] want);
    req_notes.push_back('{fixed, want});
    start_i     <= 1'b1;
    sample_in_i <= smp;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Sender gap; the data bus carries junk meanwhile
  task automatic hold_off(int unsigned n);
    start_i <= 1'b0;
    repeat (n) begin
      sample_in_i <= SW'($urandom);
      @(posedge clk_i);
    end
  endtask

  // Let every outstanding request come back before touching the gain
  task automatic drain_pipe();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sample_out_q.size() != 0 || req_notes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [GAIN_BITS-1:0] v);
    drain_pipe();
    gain_we_i    <= 1'b1;
    gain_wdata_i <= v;
    @(posedge clk_i);
    gain_we_i    <= 1'b0;
    gain_wdata_i <= GAIN_BITS'($urandom);
    n_gain_writes++;
  endtask

  initial begin
    logic [GAIN_BITS-1:0] g;
    int unsigned          idle_pct;
    bit                   tail;
    n_fail        = 0;
    n_req         = 0;
    n_res         = 0;
    n_gain_writes = 0;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    gain_we_i     = 1'b0;
    gain_wdata_i  = '0;
    sample_in_i   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, back to back
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_GAIN) begin
        write_gain(GAIN_BITS'(dir_rows[i].value));
      end else begin
        send_request(SW'(dir_rows[i].value), dir_rows[i].fixed, SW'(dir_rows[i].want));
      end
    end

    // Random phases, one gain setting each; the last two run without gaps
    for (int p = 0; p < N_PHASES; p++) begin
      case (phase_gain[p])
        GAIN_PICK_ANY:   g = GAIN_BITS'($urandom_range(0, 65535));
        GAIN_PICK_BOOST: g = GAIN_BITS'($urandom_range(int'(GAIN_ONE) + 1, int'(GAIN_MAX)));
        default:         g = GAIN_BITS'(phase_gain[p]);
      endcase
      write_gain(g);
      g        = clamp_gain(g);
      tail     = (p >= N_PHASES - 2);
      idle_pct = $urandom_range(0, 2) * 10;   // some phases have no gaps at all
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (!tail && $urandom_range(1, 100) <= idle_pct) hold_off($urandom_range(1, 15));
        send_request(pick_sample(g), 1'b0, '0);
      end
    end

    drain_pipe();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sample_out_q.size() != 0) begin
      $error("sample_out: %0d expected results never arrived", sample_out_q.size());
      n_fail++;
    end

    $display("Run covered %0d requests and %0d results over %0d gain writes,",
             n_req, n_res, n_gain_writes);
    $display("from mute through unity to the 2.0 cap, knee region included.");
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/gsl_pkg.sv
rtl/gsl_div_cell.sv
rtl/gain_with_soft_limiter_top.sv
verif/gain_with_soft_limiter_top_tb.sv
